// File: rtl/multichannel_biquad_filter_defines.svh
// Assertion helpers shared by the delay memory and the top filter module.
`ifndef MULTICHANNEL_BIQUAD_FILTER_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBQ_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbq check failed");

// Next-cycle implication, checked outside reset.
`define MBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbq check failed");

`endif

// File: rtl/mbq_pkg.sv
`default_nettype none

package mbq_pkg;

    // Channel count and channel field width
    localparam int CHANNELS = 2;
    localparam int CHAN_W   = 1;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Fixed-point formats
    localparam int FRAC   = 30;
    localparam int SMP_W  = 16;
    localparam int COEF_W = 32;
    localparam int DLY_W  = 48;
    localparam int YH_W   = DLY_W - FRAC;
    localparam int MB_T   = (FRAC + 1 > YH_W) ? FRAC + 1 : YH_W;
    localparam int MB_W   = (MB_T > SMP_W) ? MB_T : SMP_W;
    localparam int PR_W   = COEF_W + MB_W;
    localparam int ACC_W  = 82 - FRAC;
    localparam int RND_W  = DLY_W + 1 - FRAC;

    // Configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_AW-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_AW-1:0] REG_A2 = 3'd4;

    // Sequencer steps
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
    localparam logic [ST_W-1:0] ST_B0   = 4'd1;
    localparam logic [ST_W-1:0] ST_Y    = 4'd2;
    localparam logic [ST_W-1:0] ST_Z1   = 4'd3;
    localparam logic [ST_W-1:0] ST_Z2   = 4'd4;
    localparam logic [ST_W-1:0] ST_A1L  = 4'd5;
    localparam logic [ST_W-1:0] ST_A1H  = 4'd6;
    localparam logic [ST_W-1:0] ST_A2L  = 4'd7;
    localparam logic [ST_W-1:0] ST_A2H  = 4'd8;

    typedef struct packed {
        logic              load;
        logic [ST_W-1:0]   step;
    } t_dp_ctrl;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

endpackage

`default_nettype wire

// File: rtl/mbq_dly_mem.sv
`default_nettype none

`include "multichannel_biquad_filter_defines.svh"

module mbq_dly_mem
    import mbq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_ren,
    input  wire logic [CH_AW-1:0]        i_raddr,
    input  wire logic                    i_clr,
    input  wire logic                    i_wen,
    input  wire logic [CH_AW-1:0]        i_waddr,
    input  wire logic signed [DLY_W-1:0] i_wd1,
    input  wire logic signed [DLY_W-1:0] i_wd2,
    output logic signed [DLY_W-1:0]      o_rd1,
    output logic signed [DLY_W-1:0]      o_rd2
);

    logic [2*DLY_W-1:0]  r_mem [CHANNELS];
    logic [2*DLY_W-1:0]  r_rdata;
    logic                r_rd_ok;
    logic [CHANNELS-1:0] r_valid;
    logic [CHANNELS-1:0] n_valid;

    // Write one delay pair
    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= {i_wd1, i_wd2};
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Drop all entries on restart, mark an entry once written
    always_comb begin
        n_valid = r_valid;
        if (i_clr) begin
            n_valid = '0;
        end
        if (i_wen) begin
            n_valid[i_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ren) begin
                r_rd_ok <= r_valid[i_raddr] && !i_clr;
            end
        end
    end

    // An entry never written since restart reads as zero
    assign o_rd1 = r_rd_ok ? signed'(r_rdata[2*DLY_W-1:DLY_W]) : '0;
    assign o_rd2 = r_rd_ok ? signed'(r_rdata[DLY_W-1:0]) : '0;

    `MBQ_ASSERT(a_no_rw_overlap, i_clk, i_rst_n, i_wen, !i_ren)
    `MBQ_ASSERT_NEXT(a_clr_empties, i_clk, i_rst_n, i_clr && !i_wen, r_valid == '0)
    `MBQ_ASSERT_NEXT(a_wr_marks, i_clk, i_rst_n, i_wen, r_valid[$past(i_waddr)])

endmodule

`default_nettype wire

// File: rtl/mbq_dp.sv
`default_nettype none

module mbq_dp
    import mbq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_dp_ctrl                i_ctrl,
    input  wire t_coefs                  i_coefs,
    input  wire logic signed [SMP_W-1:0] i_sample,
    input  wire logic signed [DLY_W-1:0] i_rd1,
    input  wire logic signed [DLY_W-1:0] i_rd2,
    output logic signed [DLY_W-1:0]      o_wd1,
    output logic signed [DLY_W-1:0]      o_wd2,
    output logic signed [SMP_W-1:0]      o_sample
);

    logic signed [SMP_W-1:0]  r_x;
    logic signed [PR_W-1:0]   r_prod;
    logic signed [DLY_W-1:0]  r_y;
    logic signed [ACC_W-1:0]  r_acc1;
    logic signed [ACC_W-1:0]  r_acc2;
    logic signed [SMP_W-1:0]  r_res;

    logic signed [COEF_W-1:0] w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [PR_W-1:0]   w_prod;
    logic signed [YH_W-1:0]   w_yh;
    logic signed [FRAC:0]     w_yl;
    logic signed [ACC_W-1:0]  w_prod_x;
    logic signed [ACC_W-1:0]  w_prod_fl;
    logic signed [ACC_W-1:0]  w_d2_acc;

    // Clamp to the signed 48-bit range
    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DLY_W:0] hi;
        hi = v[ACC_W-1:DLY_W-1];
        if (hi == '0 || hi == {(ACC_W-DLY_W+1){1'b1}}) begin
            return v[DLY_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DLY_W-1){1'b1}}};
        end
    endfunction

    // Round half to even, then clamp to 16 bits
    function automatic logic signed [SMP_W-1:0] round_out(input logic signed [DLY_W-1:0] y);
        logic signed [DLY_W:0]   t;
        logic signed [RND_W-1:0] r;
        logic [RND_W-SMP_W:0]    hi;
        t = {y[DLY_W-1], y} + {{(DLY_W+1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
        r = t[DLY_W:FRAC];
        if (y[FRAC-1:0] == {1'b1, {(FRAC-1){1'b0}}} && r[0]) begin
            r = r - RND_W'(1);
        end
        hi = r[RND_W-1:SMP_W-1];
        if (hi == '0 || hi == {(RND_W-SMP_W+1){1'b1}}) begin
            return r[SMP_W-1:0];
        end else if (r[RND_W-1]) begin
            return {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SMP_W-1){1'b1}}};
        end
    endfunction

    // Split y into integer and fraction parts
    assign w_yh = r_y[DLY_W-1:FRAC];
    assign w_yl = signed'({1'b0, r_y[FRAC-1:0]});

    // Operand select for the shared multiplier
    always_comb begin
        unique case (i_ctrl.step)
            ST_B0: begin
                w_ma = i_coefs.b0;
                w_mb = MB_W'(r_x);
            end
            ST_Y: begin
                w_ma = i_coefs.b1;
                w_mb = MB_W'(r_x);
            end
            ST_Z1: begin
                w_ma = i_coefs.b2;
                w_mb = MB_W'(r_x);
            end
            ST_Z2: begin
                w_ma = i_coefs.a1;
                w_mb = MB_W'(w_yl);
            end
            ST_A1L: begin
                w_ma = i_coefs.a1;
                w_mb = MB_W'(w_yh);
            end
            ST_A1H: begin
                w_ma = i_coefs.a2;
                w_mb = MB_W'(w_yl);
            end
            ST_A2L: begin
                w_ma = i_coefs.a2;
                w_mb = MB_W'(w_yh);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod    = w_ma * w_mb;
    assign w_prod_x  = ACC_W'(r_prod);
    assign w_prod_fl = ACC_W'(r_prod >>> FRAC);
    assign w_d2_acc  = r_acc2 - w_prod_x;

    // Latch the sample on request
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_sample;
        end
    end

    // Multiply and accumulate, one product per step through ST_A2L
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.step)
            ST_B0: begin
                r_prod <= w_prod;
            end
            ST_Y: begin
                r_prod <= w_prod;
                r_y    <= sat_dly(w_prod_x + ACC_W'(i_rd1));
            end
            ST_Z1: begin
                r_prod <= w_prod;
                r_acc1 <= w_prod_x + ACC_W'(i_rd2);
                r_res  <= round_out(r_y);
            end
            ST_Z2: begin
                r_prod <= w_prod;
                r_acc2 <= w_prod_x;
            end
            ST_A1L: begin
                r_prod <= w_prod;
                r_acc1 <= r_acc1 - w_prod_fl;
            end
            ST_A1H: begin
                r_prod <= w_prod;
                r_acc1 <= r_acc1 - w_prod_x;
            end
            ST_A2L: begin
                r_prod <= w_prod;
                r_acc2 <= r_acc2 - w_prod_fl;
            end
            default: begin
            end
        endcase
    end

    assign o_wd1    = sat_dly(r_acc1);
    assign o_wd2    = sat_dly(w_d2_acc);
    assign o_sample = r_res;

endmodule

`default_nettype wire

// File: rtl/multichannel_biquad_filter.sv
// Two-channel biquad (transposed direct form II) on signed 16-bit samples with
// Q2.30 coefficients and 48-bit delays kept per channel in a small delay RAM.
// A sample is accepted in the idle state, which also issues its RAM read;
// then eight steps of a single shared 32x31 multiplier form b0*x, b1*x, b2*x
// and the integer and fraction halves of a1*y and a2*y, the last step writing
// the delays back once the output register is free; only then is a new sample
// accepted. The result sits in an output register, so the next sample is taken
// while it waits. A restart flag on a sample clears every channel's delays
// before that sample is filtered; coefficients are written through the plain
// write port while no sample is in flight, a rule the block leaves to the user.
`default_nettype none

`include "multichannel_biquad_filter_defines.svh"

module multichannel_biquad_filter
    import mbq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Coefficient write port
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [COEF_W-1:0] i_cfg_wdata,
    // Sample input
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,   // [15:0] sample_in
    input  wire logic [1:0]        s_axis_tuser,   // [0] chan_in, [1] restart
    // Filtered output
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]             m_axis_tuser    // [0] chan_out
);

    t_coefs                  r_coefs;
    logic [ST_W-1:0]         r_state;
    logic [ST_W-1:0]         n_state;
    logic [CH_AW-1:0]        r_addr;
    logic [CHAN_W-1:0]       r_chan;
    logic                    r_out_valid;
    logic [SMP_W-1:0]        r_out_data;
    logic [CHAN_W-1:0]       r_out_chan;

    logic                    w_accept;
    logic                    w_fin;
    logic [CHAN_W-1:0]       w_chan;
    logic [CH_AW-1:0]        w_chan_c;
    t_dp_ctrl                w_ctrl;
    logic signed [DLY_W-1:0] w_rd1;
    logic signed [DLY_W-1:0] w_rd2;
    logic signed [DLY_W-1:0] w_wd1;
    logic signed [DLY_W-1:0] w_wd2;
    logic signed [SMP_W-1:0] w_sample;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fin         = (r_state == ST_A2H) && (!r_out_valid || m_axis_tready);
    assign w_chan        = s_axis_tuser[0];

    // Map an out-of-range channel to the last one
    assign w_chan_c = (int'(w_chan) >= CHANNELS) ? CH_AW'(CHANNELS - 1) : CH_AW'(w_chan);

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= 32'sh4000_0000;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_B0:  r_coefs.b0 <= i_cfg_wdata;
                REG_B1:  r_coefs.b1 <= i_cfg_wdata;
                REG_B2:  r_coefs.b2 <= i_cfg_wdata;
                REG_A1:  r_coefs.a1 <= i_cfg_wdata;
                REG_A2:  r_coefs.a2 <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Step sequencer
    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = w_accept ? ST_B0 : ST_IDLE;
            ST_B0:   n_state = ST_Y;
            ST_Y:    n_state = ST_Z1;
            ST_Z1:   n_state = ST_Z2;
            ST_Z2:   n_state = ST_A1L;
            ST_A1L:  n_state = ST_A1H;
            ST_A1H:  n_state = ST_A2L;
            ST_A2L:  n_state = ST_A2H;
            ST_A2H:  n_state = w_fin ? ST_IDLE : ST_A2H;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold channel of the request in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= w_chan_c;
            r_chan <= w_chan;
        end
    end

    assign w_ctrl.load = w_accept;
    assign w_ctrl.step = r_state;

    mbq_dly_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ren   (w_accept),
        .i_raddr (w_chan_c),
        .i_clr   (w_accept && s_axis_tuser[1]),
        .i_wen   (w_fin),
        .i_waddr (r_addr),
        .i_wd1   (w_wd1),
        .i_wd2   (w_wd2),
        .o_rd1   (w_rd1),
        .o_rd2   (w_rd2)
    );

    mbq_dp u_dp (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_coefs  (r_coefs),
        .i_sample (signed'(s_axis_tdata[SMP_W-1:0])),
        .i_rd1    (w_rd1),
        .i_rd2    (w_rd2),
        .o_wd1    (w_wd1),
        .o_wd2    (w_wd2),
        .o_sample (w_sample)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out_data <= w_sample;
            r_out_chan <= r_chan;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_chan;

    `MBQ_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_B0)
    `MBQ_ASSERT_NEXT(a_fin_shows, i_clk, i_rst_n, w_fin,
        m_axis_tvalid && (m_axis_tuser[0] == $past(r_chan)))
    `MBQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

endmodule

`default_nettype wire
